// ----- sv/lkv_pkg.sv -----
package lkv_pkg;

    localparam int LKV_ENTRIES = 4;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // request broadcast to every cell
    typedef struct packed {
        logic             en;
        logic             put;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    // outcome of the key match and the row-full flag, broadcast back to every cell
    typedef struct packed {
        logic any_hit;
        logic full;
    } t_ctl;

    // what one cell reports about itself
    typedef struct packed {
        logic             hit;
        logic             valid;
        logic [VAL_W-1:0] value;
    } t_stat;

endpackage

// ----- sv/lkv_cell.sv -----
module lkv_cell #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES,
    parameter int RANK_W  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkv_pkg::t_req     i_req,
    input  lkv_pkg::t_ctl     i_ctl,
    input  logic [RANK_W-1:0] i_old_rank,
    input  logic              i_prev_valid,
    output lkv_pkg::t_stat    o_stat,
    output logic [RANK_W-1:0] o_rank
);
    import lkv_pkg::*;

    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ENTRIES - 1);

    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;

    logic              n_valid;
    logic [RANK_W-1:0] n_rank;
    logic [KEY_W-1:0]  n_key;
    logic [VAL_W-1:0]  n_value;

    logic hit;
    logic free_here;
    logic victim_here;
    logic target;
    logic touch;
    logic was_valid;

    assign hit         = r_valid && (r_key == i_req.key);
    // slots fill from the bottom, so the first free one follows a valid neighbour
    assign free_here   = !r_valid && i_prev_valid;
    assign victim_here = r_valid && (r_rank == LAST_RANK);
    assign touch       = i_ctl.any_hit || i_req.put;
    assign was_valid   = i_ctl.any_hit || i_ctl.full;

    always_comb begin
        if (i_ctl.any_hit) begin
            target = hit;
        end else begin
            target = i_req.put && (i_ctl.full ? victim_here : free_here);
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_key   = r_key;
        n_value = r_value;
        if (i_req.en && touch) begin
            if (target) begin
                n_valid = 1'b1;
                n_rank  = '0;
                n_key   = i_req.key;
                if (i_req.put) begin
                    n_value = i_req.value;
                end
            end else if (r_valid && (!was_valid || (r_rank < i_old_rank))) begin
                // age by one behind the slot just used
                n_rank = r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_stat.hit   = hit;
    assign o_stat.valid = r_valid;
    assign o_stat.value = r_value;
    assign o_rank       = r_rank;

endmodule

// ----- sv/lru_key_value_cache.sv -----
// Fully associative key-value cache with least-recently-used replacement.
// Request channel (s_axis): tuser carries the action (get or put), tdata the
// key and the value. Result channel (m_axis): tdata carries the hit flag, the
// value read and the eviction flag.
// Every request is compared against all slots at once; the row of cells holds
// key, value, valid bit and recency rank, and each cell learns from its lower
// neighbour whether it is the next free slot.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while m_axis is not stalled, set by the
// match and rank update across the cell row; the next request sees the
// updated state. Reset (synchronous, active low) marks every slot empty and
// drops any pending result. While the receiver holds m_axis_tready low, the
// result is held in the output register and s_axis_tready stays low, so no
// request is taken until the result has been delivered.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] key, [63:32] value
    input  logic [lkv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] hit, [32:1] read_value, [33] evicted, [39:34] zero
    output logic [lkv_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_req              req;
    t_ctl              ctl;
    t_stat             stat [ENTRIES];
    logic [RANK_W-1:0] rank [ENTRIES];
    logic [RANK_W-1:0] old_rank;
    logic [VAL_W-1:0]  hit_value;
    logic              any_hit;

    logic              r_out_valid;
    logic              r_hit;
    logic [VAL_W-1:0]  r_read_value;
    logic              r_evicted;

    assign s_axis_tready = !r_out_valid || m_axis_tready;

    assign req.en    = s_axis_tvalid && s_axis_tready;
    assign req.put   = (s_axis_tuser == ACT_PUT);
    assign req.key   = s_axis_tdata[KEY_W-1:0];
    assign req.value = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

    // keys are unique, so at most one cell hits: plain OR merges
    always_comb begin
        any_hit   = 1'b0;
        old_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            any_hit   = any_hit | stat[i].hit;
            old_rank  = old_rank | (rank[i] & {RANK_W{stat[i].hit}});
            hit_value = hit_value | (stat[i].value & {VAL_W{stat[i].hit}});
        end
        // on a miss the slot replaced in a full row is the oldest one
        if (!any_hit) begin
            old_rank = RANK_W'(ENTRIES - 1);
        end
    end

    assign ctl.any_hit = any_hit;
    assign ctl.full    = stat[ENTRIES-1].valid;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic prev_valid;
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_next
            assign prev_valid = stat[g-1].valid;
        end
        lkv_cell #(
            .ENTRIES (ENTRIES),
            .RANK_W  (RANK_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_req        (req),
            .i_ctl        (ctl),
            .i_old_rank   (old_rank),
            .i_prev_valid (prev_valid),
            .o_stat       (stat[g]),
            .o_rank       (rank[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req.en) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (req.en) begin
            r_hit        <= any_hit;
            r_read_value <= (any_hit && !req.put) ? hit_value : MISS_VALUE;
            r_evicted    <= req.put && !any_hit && ctl.full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - VAL_W - 2){1'b0}}, r_evicted, r_read_value, r_hit};

endmodule
